FILE: src/plir_pkg.sv
// ----------------------------------------------------------------------------
// plir_pkg: shared types and codes for the positional list block
// Request and response payloads, command codes, status codes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package plir_pkg;

  // Default list capacity
  localparam int DEPTH_DEF = 64;

  // Fixed field widths
  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int ITEM_W  = 12;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_FRONT = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM_BACK  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REM_AT    = 3'd5;
  localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

  // Response status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTHING    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY_DUMP = 2'd3;

  // Request payload
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item_id;
  } req_t;

  // Response payload
  typedef struct packed {
    logic [ITEM_W-1:0]  item_id_res;
    logic [STAT_W-1:0]  status;
    logic [COUNT_W-1:0] count;
    logic               last;
  } rsp_t;

  // Source of the response handle
  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_TREE  = 2'd1,
    SRC_CELL0 = 2'd2
  } src_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic              rot;
    logic              tree_adv;
    logic              out_load;
    src_t              out_src;
    logic [STAT_W-1:0] status;
    logic              last;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/plir_dp.sv
// ----------------------------------------------------------------------------
// plir_dp: list datapath
// Chain of handle cells that shift on insert, remove and dump
// rotation, a registered select tree that pulls out the removed handle, the
// entry count and the response register.
// ----------------------------------------------------------------------------
module plir_dp #(
  parameter int DEPTH = plir_pkg::DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  plir_pkg::dp_cmd_t        ctl,
  input  logic [IDX_W-1:0]         pos,
  input  logic [plir_pkg::ITEM_W-1:0] item,
  output plir_pkg::dp_stat_t       stat,
  output logic [CNT_W-1:0]         cnt,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output plir_pkg::rsp_t           rsp
);

  localparam int LEVELS = IDX_W;
  localparam int P      = 1 << LEVELS;

  logic [plir_pkg::ITEM_W-1:0] slot [DEPTH];
  logic [plir_pkg::ITEM_W-1:0] leaf [P];
  logic [plir_pkg::ITEM_W-1:0] node [1:P-1];
  logic [IDX_W-1:0]            last_idx;
  logic [CNT_W-1:0]            cnt_q;
  logic                        valid_q;
  plir_pkg::rsp_t              rsp_q;
  logic [plir_pkg::ITEM_W-1:0] sel_item;

  assign last_idx = IDX_W'(cnt_q - CNT_W'(1));

  // Cell chain: each cell looks at its neighbors, cell 0 and the command
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    localparam logic [IDX_W-1:0] I_IDX = IDX_W'(i);
    always_ff @(posedge clk) begin
      if (ctl.ins) begin
        if (I_IDX == pos) begin
          slot[i] <= item;
        end else if (I_IDX > pos) begin
          slot[i] <= slot[(i > 0) ? i - 1 : 0];
        end
      end else if (ctl.rem) begin
        if (I_IDX >= pos && i < DEPTH - 1) begin
          slot[i] <= slot[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if (ctl.rot) begin
        if (I_IDX == last_idx) begin
          slot[i] <= slot[0];
        end else if (I_IDX < last_idx) begin
          slot[i] <= slot[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  // Select leaves: only the addressed cell passes
  for (genvar i = 0; i < P; i++) begin : g_leaf
    if (i < DEPTH) begin : g_used
      assign leaf[i] = (IDX_W'(i) == pos) ? slot[i] : '0;
    end else begin : g_pad
      assign leaf[i] = '0;
    end
  end

  // OR tree, one register per node, root at node 1
  for (genvar j = 1; j < P; j++) begin : g_node
    if (2 * j >= P) begin : g_low
      always_ff @(posedge clk) begin
        if (ctl.tree_adv) begin
          node[j] <= leaf[2 * j - P] | leaf[2 * j + 1 - P];
        end
      end
    end else begin : g_high
      always_ff @(posedge clk) begin
        if (ctl.tree_adv) begin
          node[j] <= node[2 * j] | node[2 * j + 1];
        end
      end
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_q <= '0;
    end else if (ctl.ins) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (ctl.rem) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // Response handle source
  always_comb begin
    case (ctl.out_src)
      plir_pkg::SRC_TREE:  sel_item = node[1];
      plir_pkg::SRC_CELL0: sel_item = slot[0];
      default:             sel_item = '0;
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      valid_q <= 1'b1;
    end else if (rsp_ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      rsp_q.item_id_res <= sel_item;
      rsp_q.status      <= ctl.status;
      rsp_q.count       <= plir_pkg::COUNT_W'(cnt_q);
      rsp_q.last        <= ctl.last;
    end
  end

  assign rsp_valid     = valid_q;
  assign rsp           = rsp_q;
  assign cnt           = cnt_q;
  assign stat.full     = (cnt_q == CNT_W'(DEPTH));
  assign stat.empty    = (cnt_q == '0);
  assign stat.out_free = !valid_q || rsp_ready;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above capacity");
  a_ins_room: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |-> !stat.full && !ctl.rem && !ctl.rot)
    else $error("insert into full list or mixed shift");
  a_rem_have: assert property (@(posedge clk) disable iff (rst)
    (ctl.rem || ctl.rot) |-> !stat.empty)
    else $error("remove or rotate on empty list");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> stat.out_free)
    else $error("response overwritten before taken");
`endif

endmodule

FILE: src/plir_ctrl.sv
// ----------------------------------------------------------------------------
// plir_ctrl: list controller
// Decodes each request, clamps and checks positions, steps the datapath
// through shift, select-tree wait, response and dump streaming.
// ----------------------------------------------------------------------------
module plir_ctrl #(
  parameter int DEPTH = plir_pkg::DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  plir_pkg::req_t     req,
  input  logic [CNT_W-1:0]   cnt,
  input  plir_pkg::dp_stat_t stat,
  output plir_pkg::dp_cmd_t  ctl,
  output logic [IDX_W-1:0]   pos
);

  localparam int LEVELS = IDX_W;
  localparam int WAIT_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int MW     = (CNT_W > plir_pkg::POS_W) ? CNT_W : plir_pkg::POS_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TREE = 4'b0010,
    S_EMIT = 4'b0100,
    S_DUMP = 4'b1000
  } state_t;

  state_t                      state, state_next;
  logic [WAIT_W-1:0]           wait_cnt, wait_next;
  logic [CNT_W-1:0]            remaining, remaining_next;
  logic [plir_pkg::STAT_W-1:0] status_q, status_next;
  plir_pkg::src_t              src_q, src_next;

  logic [MW-1:0]    pos_ext;
  logic [MW-1:0]    cnt_ext;
  logic [IDX_W-1:0] ins_pos;
  logic [IDX_W-1:0] rem_pos;
  logic             rem_err;

  // Position clamp and range check
  always_comb begin
    pos_ext = MW'(req.position);
    cnt_ext = MW'(cnt);
    case (req.cmd)
      plir_pkg::CMD_INS_FRONT: ins_pos = '0;
      plir_pkg::CMD_INS_BACK:  ins_pos = IDX_W'(cnt);
      default:                 ins_pos = (pos_ext > cnt_ext) ? IDX_W'(cnt)
                                                             : IDX_W'(req.position);
    endcase
    case (req.cmd)
      plir_pkg::CMD_REM_FRONT: rem_pos = '0;
      plir_pkg::CMD_REM_BACK:  rem_pos = IDX_W'(cnt - CNT_W'(1));
      default:                 rem_pos = IDX_W'(req.position);
    endcase
    rem_err = stat.empty || (req.cmd == plir_pkg::CMD_REM_AT && pos_ext >= cnt_ext);
  end

  // Next state and datapath commands
  always_comb begin
    state_next     = state;
    wait_next      = wait_cnt;
    remaining_next = remaining;
    status_next    = status_q;
    src_next       = src_q;
    ctl            = '0;
    pos            = '0;
    req_ready      = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req.cmd) inside
            plir_pkg::CMD_INS_FRONT, plir_pkg::CMD_INS_BACK, plir_pkg::CMD_INS_AT: begin
              src_next   = plir_pkg::SRC_ZERO;
              state_next = S_EMIT;
              if (stat.full) begin
                status_next = plir_pkg::ST_FULL;
              end else begin
                status_next = plir_pkg::ST_OK;
                ctl.ins     = 1'b1;
                pos         = ins_pos;
              end
            end
            plir_pkg::CMD_REM_FRONT, plir_pkg::CMD_REM_BACK, plir_pkg::CMD_REM_AT: begin
              if (rem_err) begin
                status_next = plir_pkg::ST_NOTHING;
                src_next    = plir_pkg::SRC_ZERO;
                state_next  = S_EMIT;
              end else begin
                status_next  = plir_pkg::ST_OK;
                src_next     = plir_pkg::SRC_TREE;
                ctl.rem      = 1'b1;
                ctl.tree_adv = 1'b1;
                pos          = rem_pos;
                wait_next    = WAIT_W'(LEVELS - 1);
                state_next   = S_TREE;
              end
            end
            plir_pkg::CMD_DUMP: begin
              if (stat.empty) begin
                status_next = plir_pkg::ST_EMPTY_DUMP;
                src_next    = plir_pkg::SRC_ZERO;
                state_next  = S_EMIT;
              end else begin
                remaining_next = cnt;
                state_next     = S_DUMP;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_TREE: begin
        // Root of the select tree settles once every level has advanced
        if (wait_cnt == '0) begin
          state_next = S_EMIT;
        end else begin
          ctl.tree_adv = 1'b1;
          wait_next    = wait_cnt - WAIT_W'(1);
        end
      end
      S_EMIT: begin
        ctl.out_src = src_q;
        ctl.status  = status_q;
        ctl.last    = 1'b1;
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_DUMP: begin
        // Stream the front cell and rotate the list by one per response
        ctl.out_src = plir_pkg::SRC_CELL0;
        ctl.status  = plir_pkg::ST_OK;
        ctl.last    = (remaining == CNT_W'(1));
        if (stat.out_free) begin
          ctl.out_load   = 1'b1;
          ctl.rot        = 1'b1;
          remaining_next = remaining - CNT_W'(1);
          if (remaining == CNT_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_cnt  <= '0;
      remaining <= '0;
      status_q  <= plir_pkg::ST_OK;
      src_q     <= plir_pkg::SRC_ZERO;
    end else begin
      state     <= state_next;
      wait_cnt  <= wait_next;
      remaining <= remaining_next;
      status_q  <= status_next;
      src_q     <= src_next;
    end
  end

`ifndef SYNTHESIS
  a_dump_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DUMP |-> remaining != '0)
    else $error("dump running with nothing left");
  a_dump_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && req_valid && req.cmd == plir_pkg::CMD_DUMP && !stat.empty)
      |=> (state == S_DUMP && remaining == $past(cnt)))
    else $error("dump did not start with full count");
  a_tree_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_TREE && wait_cnt == '0) |-> !ctl.tree_adv)
    else $error("select tree moved after settling");
`endif

endmodule

FILE: src/positional_list_insert_remove.sv
// Insert, remove-error and full-list requests: response loaded in the emit state.
// Remove that succeeds: response loaded once the registered select tree,
//   which pulls the handle out of the chain, has settled.
// Dump: one entry per cycle from the front cell while responses are taken.
// One request at a time; a new one is taken once the response is loaded.
// Reset empties the list (count 0); stored handles are not cleared.
// ----------------------------------------------------------------------------
// positional_list_insert_remove: bounded ordered list of item handles
// Insert and remove at front, back or position, and in-order dump, built as a
// controller and a shifting cell-chain datapath.
// ----------------------------------------------------------------------------
module positional_list_insert_remove #(
  parameter int DEPTH = plir_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  plir_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output plir_pkg::rsp_t rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  plir_pkg::dp_cmd_t  ctl;
  plir_pkg::dp_stat_t stat;
  logic [IDX_W-1:0]   pos;
  logic [CNT_W-1:0]   cnt;

  plir_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cnt       (cnt),
    .stat      (stat),
    .ctl       (ctl),
    .pos       (pos)
  );

  plir_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .pos       (pos),
    .item      (req.item_id),
    .stat      (stat),
    .cnt       (cnt),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
